// File: src/word_tokenizer_stream_defines.svh
// Assertion macros for the word tokenizer stream.
`ifndef WORD_TOKENIZER_STREAM_DEFINES_SVH
`define WORD_TOKENIZER_STREAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("word tokenizer check failed");

// Next-cycle implication, checked outside reset.
`define WTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("word tokenizer check failed");

`endif

// File: src/wts_pkg.sv
`timescale 1ns / 1ps

package wts_pkg;

  // Character constants used by the classifier.
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] CH_A_LOW  = 8'h61;
  localparam logic [7:0] CH_Z_LOW  = 8'h7a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_AT     = 8'h40;

  // One input transfer.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] word_byte;
    logic       has_byte;
    logic       word_done;
    logic       last_of_run;
  } out_t;

  // Work handed from the front to the back: an optional held symbol, then
  // either a character or a word-end mark.
  typedef struct packed {
    logic       has_sym;
    logic [7:0] sym;
    logic       main_is_byte;
    logic [7:0] main_byte;
  } job_t;

  // Scanner position.
  typedef enum logic [2:0] {
    ST_BETWEEN = 3'b001,
    ST_ALNUM   = 3'b010,
    ST_SYMBOL  = 3'b100
  } scan_t;

endpackage

// File: src/word_tokenizer_stream.sv
`timescale 1ns / 1ps

// Word tokenizer: takes one text byte per transfer and returns the lowercased
// characters of each word, followed by a word-end mark. A new byte is accepted
// every cycle while the job queue between the scanner and the output stage
// has room (QUEUE_DEPTH entries). Most bytes give zero or one result; an
// alphanumeric that follows a held in-word symbol gives two, but the symbol
// before it gave none, so with three queue entries the block keeps taking one
// byte per cycle as long as the output is not stalled. The first result of an
// accepted byte is written into the job queue and then into the output register
// before it can transfer.
module word_tokenizer_stream #(
  parameter int QUEUE_DEPTH = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_stall,
  input  wts_pkg::in_t   src_item,
  output logic           dst_valid,
  input  logic           dst_stall,
  output wts_pkg::out_t  dst_item
);
  import wts_pkg::*;

`include "word_tokenizer_stream_defines.svh"

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t head_job;

  // Scanner: classifies bytes and tracks word state.
  wts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // Job queue between scanner and output stage.
  wts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Output stage: expands each job into one or two results.
  wts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .q_pop       (q_pop),
    .dst_valid   (dst_valid),
    .dst_stall   (dst_stall),
    .dst_item    (dst_item)
  );

  // The scanner never pushes into a full queue.
  `WTS_ASSERT_NOW(a_no_overflow, q_push, !q_full)
  // A word-end mark carries no character and always closes its run.
  `WTS_ASSERT_NOW(a_end_shape, dst_valid && dst_item.word_done,
                  !dst_item.has_byte && dst_item.last_of_run && dst_item.word_byte == 8'h00)
  // A result that is not the last of its run is a held symbol, and the
  // character that completes the run is shown next once it is taken.
  `WTS_ASSERT_NEXT(a_pair_follows, dst_valid && !dst_stall && !dst_item.last_of_run,
                   dst_valid && dst_item.has_byte && dst_item.last_of_run)

endmodule

// File: src/wts_front.sv
`timescale 1ns / 1ps

module wts_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_stall,
  input  wts_pkg::in_t   src_item,
  input  logic           q_full,
  output logic           q_push,
  output wts_pkg::job_t  q_job
);
  import wts_pkg::*;

  scan_t      state;
  scan_t      state_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic       accept;
  logic       need_job;
  logic       in_word;
  logic [7:0] folded;
  logic       alpha_hit;
  logic       is_digit;
  logic       is_symbol;
  logic [7:0] lowered;
  job_t       job;

  assign src_stall = q_full;
  assign accept    = src_valid && !q_full;

  // Byte classification.
  assign folded    = src_item.text_byte | CASE_BIT;
  assign alpha_hit = (folded >= CH_A_LOW) && (folded <= CH_Z_LOW);
  assign is_digit  = (src_item.text_byte >= CH_ZERO) && (src_item.text_byte <= CH_NINE);
  assign is_symbol = (src_item.text_byte == CH_DASH)  || (src_item.text_byte == CH_QUOTE) ||
                     (src_item.text_byte == CH_PCT)   || (src_item.text_byte == CH_COMMA) ||
                     (src_item.text_byte == CH_DOT)   || (src_item.text_byte == CH_AT);
  assign lowered   = alpha_hit ? folded : src_item.text_byte;
  assign in_word   = (state == ST_ALNUM) || (state == ST_SYMBOL);

  // Scanner step: next state and the work it leaves for the back end.
  always_comb begin
    state_next       = state;
    held_next        = held;
    need_job         = 1'b0;
    job.has_sym      = 1'b0;
    job.sym          = held;
    job.main_is_byte = 1'b0;
    job.main_byte    = 8'h00;
    priority if (src_item.end_of_text) begin
      need_job   = in_word;
      state_next = ST_BETWEEN;
      held_next  = 8'h00;
    end else if (alpha_hit || is_digit) begin
      need_job         = 1'b1;
      job.has_sym      = (state == ST_SYMBOL);
      job.main_is_byte = 1'b1;
      job.main_byte    = lowered;
      state_next       = ST_ALNUM;
      held_next        = 8'h00;
    end else if ((state == ST_ALNUM) && is_symbol) begin
      state_next = ST_SYMBOL;
      held_next  = src_item.text_byte;
    end else begin
      need_job   = in_word;
      state_next = ST_BETWEEN;
      held_next  = 8'h00;
    end
  end

  assign q_push = accept && need_job;
  assign q_job  = job;

  // Scanner state registers, updated on each accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BETWEEN;
      held  <= 8'h00;
    end else if (accept) begin
      state <= state_next;
      held  <= held_next;
    end
  end

endmodule

// File: src/wts_queue.sv
`timescale 1ns / 1ps

module wts_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wts_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output wts_pkg::job_t  head_job
);
  import wts_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/wts_back.sv
`timescale 1ns / 1ps

module wts_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  wts_pkg::job_t  q_job,
  output logic           q_pop,
  output logic           dst_valid,
  input  logic           dst_stall,
  output wts_pkg::out_t  dst_item
);
  import wts_pkg::*;

  logic out_valid;
  out_t out_reg;
  logic sym_sent;
  logic load;
  logic take;
  logic sym_turn;
  out_t result;

  // The output register can take a new result when empty or being drained.
  assign load     = !out_valid || !dst_stall;
  assign take     = load && q_not_empty;
  assign sym_turn = q_job.has_sym && !sym_sent;
  assign q_pop    = take && !sym_turn;

  // Pick the held symbol first, then the character or word-end mark.
  always_comb begin
    if (sym_turn) begin
      result.word_byte   = q_job.sym;
      result.has_byte    = 1'b1;
      result.word_done   = 1'b0;
      result.last_of_run = 1'b0;
    end else begin
      result.word_byte   = q_job.main_byte;
      result.has_byte    = q_job.main_is_byte;
      result.word_done   = !q_job.main_is_byte;
      result.last_of_run = 1'b1;
    end
  end

  // Output register and the symbol phase bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sym_sent  <= 1'b0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (take) begin
        sym_sent <= sym_turn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_reg <= result;
    end
  end

  assign dst_valid = out_valid;
  assign dst_item  = out_reg;

endmodule

// File: test/word_tokenizer_stream_tb.sv
`timescale 1ns / 1ps

module word_tokenizer_stream_tb;
  import wts_pkg::*;

  localparam int RANDOM_ITEMS = 1025;
  localparam int QUIET_FROM = 850;
  localparam int SETTLE_CYCLES = 20;
  localparam out_t WORD_END = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam out_t NO_RESULT = '{8'h00, 1'b0, 1'b0, 1'b0};
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One row of the directed script; a negative count means the tokenizer model decides.
  typedef struct {
    in_t  item;
    int   typed_n;
    out_t first;
    out_t second;
  } text_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  in_t  src_item = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  out_t dst_item;

  // Tokenizer model state and the words it still expects to see.
  scan_t      scan_pos = ST_BETWEEN;
  logic [7:0] held_sym = 8'h00;
  out_t       pending_tokens[$];
  text_row_t  script_rows[$];
  int         mismatch_count = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;

  word_tokenizer_stream i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic out_t char_res(input logic [7:0] c, input logic last);
    char_res = '{c, 1'b1, 1'b0, last};
  endfunction

  // Advance the tokenizer model by one transfer and return its results.
  function automatic int tokenize(input in_t item, output out_t r0, output out_t r1);
    logic [7:0] c;
    logic [7:0] folded;
    logic       letter;
    logic       digit;
    logic       symbol;
    logic       in_word;
    int         n;
    n = 0;
    r0 = NO_RESULT;
    r1 = NO_RESULT;
    c = item.text_byte;
    folded = c | CASE_BIT;
    letter = (folded >= CH_A_LOW) && (folded <= CH_Z_LOW);
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    symbol = (c == CH_DASH) || (c == CH_QUOTE) || (c == CH_PCT) || (c == CH_COMMA) ||
             (c == CH_DOT) || (c == CH_AT);
    in_word = (scan_pos == ST_ALNUM) || (scan_pos == ST_SYMBOL);
    if (item.end_of_text) begin
      if (in_word) begin
        r0 = WORD_END;
        n = 1;
      end
      scan_pos = ST_BETWEEN;
      held_sym = 8'h00;
    end else if (letter || digit) begin
      if (scan_pos == ST_SYMBOL) begin
        r0 = char_res(held_sym, 1'b0);
        r1 = char_res(letter ? folded : c, 1'b1);
        n = 2;
      end else begin
        r0 = char_res(letter ? folded : c, 1'b1);
        n = 1;
      end
      scan_pos = ST_ALNUM;
      held_sym = 8'h00;
    end else if (scan_pos == ST_ALNUM && symbol) begin
      held_sym = c;
      scan_pos = ST_SYMBOL;
    end else begin
      if (in_word) begin
        r0 = WORD_END;
        n = 1;
      end
      scan_pos = ST_BETWEEN;
      held_sym = 8'h00;
    end
    return n;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic eot, input int n,
                         input out_t first, input out_t second);
    text_row_t row;
    row.item = '{b, eot};
    row.typed_n = n;
    row.first = first;
    row.second = second;
    script_rows.push_back(row);
  endtask

  // Hold one transfer until accepted, log what it should produce, then maybe idle.
  task automatic push_text(input in_t item, input int typed_n, input out_t first,
                           input out_t second, input bit allow_gap);
    out_t r0;
    out_t r1;
    int   n;
    src_item <= item;
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    n = tokenize(item, r0, r1);
    if (typed_n >= 0) begin
      n = typed_n;
      r0 = first;
      r1 = second;
    end
    if (n > 0) pending_tokens.push_back(r0);
    if (n > 1) pending_tokens.push_back(r1);
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Mostly word-like text with random content, plus noise and end-of-text marks.
  function automatic in_t random_text();
    in_t        item;
    int         pick;
    logic [7:0] symbols[6];
    symbols = '{CH_DASH, CH_QUOTE, CH_PCT, CH_COMMA, CH_DOT, CH_AT};
    pick = $urandom_range(0, 99);
    item.end_of_text = 1'b0;
    if (pick < 35) begin
      item.text_byte = 8'($urandom_range(CH_A_LOW, CH_Z_LOW));
      if ($urandom_range(0, 1) == 1) item.text_byte = item.text_byte & ~CASE_BIT;
    end else if (pick < 50) begin
      item.text_byte = 8'($urandom_range(CH_ZERO, CH_NINE));
    end else if (pick < 65) begin
      item.text_byte = symbols[$urandom_range(0, 5)];
    end else if (pick < 75) begin
      item.text_byte = CH_SPACE;
    end else if (pick < 95) begin
      item.text_byte = 8'($urandom_range(0, 255));
    end else begin
      item.text_byte = 8'($urandom_range(0, 255));
      item.end_of_text = 1'b1;
    end
    return item;
  endfunction

  // Compare each accepted result with the oldest expected one, and stall at random.
  always @(posedge clk) begin
    out_t want;
    if (!rst && dst_valid && !dst_stall) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", dst_item));
      end else begin
        want = pending_tokens.pop_front();
        if (dst_item.word_byte !== want.word_byte)
          report_mismatch($sformatf("word_byte %h, expected %h",
                                    dst_item.word_byte, want.word_byte));
        if (dst_item.has_byte !== want.has_byte)
          report_mismatch($sformatf("has_byte %b, expected %b",
                                    dst_item.has_byte, want.has_byte));
        if (dst_item.word_done !== want.word_done)
          report_mismatch($sformatf("word_done %b, expected %b",
                                    dst_item.word_done, want.word_done));
        if (dst_item.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, expected %b",
                                    dst_item.last_of_run, want.last_of_run));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      dst_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      dst_stall <= 1'b1;
    end else begin
      dst_stall <= 1'b0;
    end
  end

  // Main sequence: reset, directed script, random text, drain.
  initial begin
    int settle;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed script: case folding, held symbols, word ends and byte extremes.
    add_row(8'h41, 1'b0, 1, char_res(8'h61, 1'b1), NO_RESULT);
    add_row(8'h5a, 1'b0, 1, char_res(8'h7a, 1'b1), NO_RESULT);
    add_row(CH_DASH, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(CH_ZERO, 1'b0, 2, char_res(CH_DASH, 1'b0), char_res(CH_ZERO, 1'b1));
    add_row(CH_NINE, 1'b0, 1, char_res(CH_NINE, 1'b1), NO_RESULT);
    // Two symbols in a row drop the first and end the word.
    add_row(CH_QUOTE, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(CH_QUOTE, 1'b0, 1, WORD_END, NO_RESULT);
    add_row(8'h61, 1'b0, 1, char_res(8'h61, 1'b1), NO_RESULT);
    add_row(CH_PCT, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(CH_SPACE, 1'b0, 1, WORD_END, NO_RESULT);
    // A symbol or an end of text between words is ignored.
    add_row(CH_COMMA, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
    add_row(8'h4d, 1'b0, -1, NO_RESULT, NO_RESULT);
    add_row(CH_DOT, 1'b0, 0, NO_RESULT, NO_RESULT);
    // End of text after a held symbol drops the symbol.
    add_row(8'hff, 1'b1, 1, WORD_END, NO_RESULT);
    add_row(CH_AT, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h7a, 1'b0, -1, NO_RESULT, NO_RESULT);
    add_row(CH_AT, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h51, 1'b0, 2, char_res(CH_AT, 1'b0), char_res(8'h71, 1'b1));
    add_row(8'hff, 1'b0, 1, WORD_END, NO_RESULT);
    add_row(8'h00, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(8'hc1, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h5b, 1'b0, 0, NO_RESULT, NO_RESULT);
    add_row(CH_NINE, 1'b0, 1, char_res(CH_NINE, 1'b1), NO_RESULT);
    // End of text inside a word ignores its text byte.
    add_row(8'h61, 1'b1, 1, WORD_END, NO_RESULT);

    foreach (script_rows[i])
      push_text(script_rows[i].item, script_rows[i].typed_n, script_rows[i].first,
                script_rows[i].second, 1'b1);

    // Let the block run dry before the random text starts.
    src_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= QUIET_FROM);
      push_text(random_text(), -1, NO_RESULT, NO_RESULT, !quiet);
    end
    src_valid <= 1'b0;

    // Wait for the tail, then keep watching for stray results.
    while (pending_tokens.size() != 0) @(posedge clk);
    for (settle = 0; settle < SETTLE_CYCLES; settle++) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
